// ===== src/lcbw_pkg.sv =====
// ----------------------------------------------------------------------------
// lcbw_pkg
// Shared widths and register codes of the load cell bridge weigher.
// ----------------------------------------------------------------------------
package lcbw_pkg;

	// payload widths
	localparam int RAW_W    = 24;
	localparam int CHAN_W   = 2;
	localparam int WEIGHT_W = 64;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// calibration formats
	localparam int SPAN_W = 48;
	localparam int ZERO_W = 32;

	// running state
	localparam int SUM_W = 27;
	localparam int CNT_W = 3;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAL_VALID = 3'd0,
		CFG_SPAN_CH1  = 3'd1,
		CFG_SPAN_CH2  = 3'd2,
		CFG_SPAN_CH3  = 3'd3,
		CFG_SPAN_CH4  = 3'd4,
		CFG_ZERO_CH12 = 3'd5,
		CFG_ZERO_CH34 = 3'd6
	} cfg_reg_t;

endpackage

// ===== src/lcbw_in_if.sv =====
// ----------------------------------------------------------------------------
// lcbw_in_if
// Raw converter code channel: valid, ready and one code per beat.
// ----------------------------------------------------------------------------
interface lcbw_in_if import lcbw_pkg::*;;

	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] raw_code;

	modport source (output valid, output raw_code, input ready);
	modport sink   (input valid, input raw_code, output ready);

endinterface

// ===== src/lcbw_out_if.sv =====
// ----------------------------------------------------------------------------
// lcbw_out_if
// Result channel: next channel select and calibrated weight per beat.
// ----------------------------------------------------------------------------
interface lcbw_out_if import lcbw_pkg::*;;

	logic                       valid;
	logic                       ready;
	logic [CHAN_W-1:0]          next_channel;
	logic signed [WEIGHT_W-1:0] weight;
	logic                       weight_valid;

	modport source (output valid, output next_channel, output weight, output weight_valid,
		input ready);
	modport sink   (input valid, input next_channel, input weight, input weight_valid,
		output ready);

endinterface

// ===== src/load_cell_bridge_weigher.sv =====
// ----------------------------------------------------------------------------
// load_cell_bridge_weigher
// Averages SAMPLES codes per channel over CHANNELS channels, removes each
// channel's zero offset, scales by its span and sums a saturating weight.
//
//   channel | dir | beat contents
//   --------+-----+------------------------------------------
//   in      | in  | raw_code
//   out     | out | next_channel, weight, weight_valid
//   cfg     | in  | cfg_we, cfg_index, cfg_data (write only)
//
// One beat is accepted per cycle while the pipeline is not stalled; each result
// passes through a seven-stage pipeline (sum, reciprocal multiply, quotient
// fix-up, offset, two partial products, reduce, accumulate).
// Stalls on out ripple back stage by stage, so empty stages keep taking beats.
// Reset clears the channel state, the accumulator, the stage valids and the
// configuration registers.
// ----------------------------------------------------------------------------
module load_cell_bridge_weigher import lcbw_pkg::*; #(
	parameter int SAMPLES   = 5,
	parameter int CHANNELS  = 4,
	parameter int CODE_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	lcbw_in_if.sink               in,
	lcbw_out_if.source            out,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int STAGES    = 7;
	localparam int ABS_W     = SUM_W - 1;
	localparam int RECIP_SH  = 28;
	localparam int RECIP_W   = RECIP_SH + 1;
	localparam int PROD_W    = ABS_W + RECIP_W;
	localparam int AVG_W     = 34;
	localparam int DMAG_W    = AVG_W - 1;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / SAMPLES);
	localparam logic [7:0] FRAC_TAB [8] = '{
		8'(0),             8'(256 / SAMPLES),  8'(512 / SAMPLES),  8'(768 / SAMPLES),
		8'(1024 / SAMPLES), 8'(1280 / SAMPLES), 8'(1536 / SAMPLES), 8'(1792 / SAMPLES)
	};
	localparam logic signed [WEIGHT_W-1:0] W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
	localparam logic signed [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

	// configuration registers
	logic                     cal_valid_q;
	logic signed [SPAN_W-1:0] span_q [4];
	logic [CFG_DATA_W-1:0]    zero12_q;
	logic [CFG_DATA_W-1:0]    zero34_q;

	// channel state
	logic [CHAN_W-1:0]        chan_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [WEIGHT_W-1:0] acc_q;

	// stage valids and ready chain
	logic [STAGES:1] vld_q;
	logic [STAGES:1] rdy;

	// pipeline payload
	logic signed [SUM_W-1:0]    sum_s1;
	logic [CHAN_W-1:0]          ch_s1, ch_s2, ch_s3;
	logic [CHAN_W-1:0]          nxt_s1, nxt_s2, nxt_s3, nxt_s4, nxt_s5, nxt_s6, nxt_s7;
	logic                       done_s1, done_s2, done_s3, done_s4, done_s5, done_s6;
	logic                       last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;
	logic [ABS_W-1:0]           abs_s2;
	logic                       neg_s2, neg_s4, neg_s5;
	logic [PROD_W-1:0]          prod_s2;
	logic signed [AVG_W-1:0]    avg_s3;
	logic [SPAN_W-1:0]          smag_s4;
	logic [DMAG_W-1:0]          dmag_s4;
	logic [32+DMAG_W-1:0]       plo_s5;
	logic [SPAN_W-32+DMAG_W-1:0] phi_s5;
	logic signed [WEIGHT_W-1:0] term_s6;
	logic signed [WEIGHT_W-1:0] weight_s7;
	logic                       wvalid_s7;

	// write configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++) span_q[i] <= '0;
			zero12_q <= '0;
			zero34_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CAL_VALID: cal_valid_q <= cfg_data[0];
				CFG_SPAN_CH1:  span_q[0] <= SPAN_W'(cfg_data);
				CFG_SPAN_CH2:  span_q[1] <= SPAN_W'(cfg_data);
				CFG_SPAN_CH3:  span_q[2] <= SPAN_W'(cfg_data);
				CFG_SPAN_CH4:  span_q[3] <= SPAN_W'(cfg_data);
				CFG_ZERO_CH12: zero12_q <= cfg_data;
				CFG_ZERO_CH34: zero34_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ready ripples back from the output register
	always_comb begin
		rdy[STAGES] = !vld_q[STAGES] || out.ready;
		for (int k = STAGES - 1; k >= 1; k--) rdy[k] = !vld_q[k] || rdy[k+1];
	end

	assign in.ready = rdy[1];

	// advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) vld_q[1] <= in.valid;
			for (int k = 2; k <= STAGES; k++) begin
				if (rdy[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// stage 1: sign-extend the code and update channel state
	logic                    acc_in;
	logic signed [SUM_W-1:0] code_ext;
	logic signed [SUM_W-1:0] sum_in;
	logic                    done_in;
	logic                    last_in;
	logic [CHAN_W-1:0]       nxt_in;

	assign acc_in   = in.valid && rdy[1];
	assign code_ext = SUM_W'($signed(in.raw_code[CODE_BITS-1:0]));
	assign sum_in   = sum_q + code_ext;
	assign done_in  = (cnt_q == CNT_W'(SAMPLES - 1));
	assign last_in  = (chan_q == CHAN_W'(CHANNELS - 1));
	assign nxt_in   = !done_in ? chan_q : (last_in ? '0 : chan_q + 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= '0;
			cnt_q  <= '0;
			sum_q  <= '0;
		end else if (acc_in) begin
			chan_q <= nxt_in;
			if (done_in) begin
				cnt_q <= '0;
				sum_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
				sum_q <= sum_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			sum_s1  <= sum_in;
			ch_s1   <= chan_q;
			nxt_s1  <= nxt_in;
			done_s1 <= done_in;
			last_s1 <= last_in;
		end
	end

	// stage 2: magnitude of the sum times the reciprocal of SAMPLES
	logic [SUM_W-1:0] sum_abs;

	assign sum_abs = sum_s1[SUM_W-1] ? SUM_W'(-sum_s1) : SUM_W'(sum_s1);

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			abs_s2  <= sum_abs[ABS_W-1:0];
			neg_s2  <= sum_s1[SUM_W-1];
			prod_s2 <= PROD_W'(sum_abs[ABS_W-1:0]) * PROD_W'(RECIP);
			ch_s2   <= ch_s1;
			nxt_s2  <= nxt_s1;
			done_s2 <= done_s1;
			last_s2 <= last_s1;
		end
	end

	// stage 3: fix up the quotient and form the signed Q26.8 average
	logic [ABS_W-1:0] quo_est;
	logic [SUM_W-1:0] rem_est;
	logic [ABS_W-1:0] quo;
	logic [2:0]       rem;
	logic [AVG_W-1:0] avg_mag;

	always_comb begin
		quo_est = prod_s2[RECIP_SH +: ABS_W];
		rem_est = SUM_W'(abs_s2) - SUM_W'(quo_est) * SUM_W'(SAMPLES);
		if (rem_est >= SUM_W'(SAMPLES)) begin
			quo = quo_est + 1'b1;
			rem = 3'(rem_est - SUM_W'(SAMPLES));
		end else begin
			quo = quo_est;
			rem = 3'(rem_est);
		end
		avg_mag = AVG_W'({quo, 8'h00}) + AVG_W'(FRAC_TAB[rem]);
	end

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			avg_s3  <= neg_s2 ? AVG_W'(-avg_mag) : AVG_W'(avg_mag);
			ch_s3   <= ch_s2;
			nxt_s3  <= nxt_s2;
			done_s3 <= done_s2;
			last_s3 <= last_s2;
		end
	end

	// stage 4: subtract the zero offset, split into sign and magnitudes
	logic [ZERO_W-1:0]        zero_sel;
	logic signed [AVG_W-1:0]  diff;
	logic signed [SPAN_W-1:0] span_sel;

	always_comb begin
		case (ch_s3)
			2'd0:    zero_sel = zero12_q[ZERO_W-1:0];
			2'd1:    zero_sel = zero12_q[2*ZERO_W-1:ZERO_W];
			2'd2:    zero_sel = zero34_q[ZERO_W-1:0];
			default: zero_sel = zero34_q[2*ZERO_W-1:ZERO_W];
		endcase
		span_sel = span_q[ch_s3];
		diff     = avg_s3 - AVG_W'($signed(zero_sel));
	end

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			smag_s4 <= span_sel[SPAN_W-1] ? SPAN_W'(-span_sel) : SPAN_W'(span_sel);
			dmag_s4 <= diff[AVG_W-1] ? DMAG_W'(-diff) : DMAG_W'(diff);
			neg_s4  <= span_sel[SPAN_W-1] ^ diff[AVG_W-1];
			nxt_s4  <= nxt_s3;
			done_s4 <= done_s3;
			last_s4 <= last_s3;
		end
	end

	// stage 5: low and high partial products of span times offset
	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			plo_s5  <= (32+DMAG_W)'(smag_s4[31:0]) * (32+DMAG_W)'(dmag_s4);
			phi_s5  <= (SPAN_W-32+DMAG_W)'(smag_s4[SPAN_W-1:32])
				* (SPAN_W-32+DMAG_W)'(dmag_s4);
			neg_s5  <= neg_s4;
			nxt_s5  <= nxt_s4;
			done_s5 <= done_s4;
			last_s5 <= last_s4;
		end
	end

	// stage 6: reduce to Q40.24, truncate toward zero, saturate
	logic [WEIGHT_W-1:0] mag;

	always_comb begin
		mag = WEIGHT_W'({phi_s5, 16'h0000}) + WEIGHT_W'(plo_s5[32+DMAG_W-1:16]);
	end

	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			if (neg_s5) term_s6 <= mag[WEIGHT_W-1] ? W_MIN : WEIGHT_W'(-mag);
			else        term_s6 <= mag[WEIGHT_W-1] ? W_MAX : WEIGHT_W'(mag);
			nxt_s6  <= nxt_s5;
			done_s6 <= done_s5;
			last_s6 <= last_s5;
		end
	end

	// stage 7: saturating accumulate, emit the weight after the last channel
	logic [WEIGHT_W:0]          acc_wide;
	logic signed [WEIGHT_W-1:0] acc_sat;
	logic                       acc_take;

	always_comb begin
		acc_wide = {acc_q[WEIGHT_W-1], acc_q} + {term_s6[WEIGHT_W-1], term_s6};
		if (acc_wide[WEIGHT_W] != acc_wide[WEIGHT_W-1])
			acc_sat = acc_wide[WEIGHT_W] ? W_MIN : W_MAX;
		else
			acc_sat = acc_wide[WEIGHT_W-1:0];
		acc_take = vld_q[6] && rdy[7] && done_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (acc_take) begin
			acc_q <= last_s6 ? '0 : acc_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[7]) begin
			nxt_s7    <= nxt_s6;
			wvalid_s7 <= done_s6 && last_s6;
			weight_s7 <= (done_s6 && last_s6 && cal_valid_q) ? acc_sat : '0;
		end
	end

	assign out.valid        = vld_q[STAGES];
	assign out.next_channel = nxt_s7;
	assign out.weight       = weight_s7;
	assign out.weight_valid = wvalid_s7;

`ifndef ASSERT_OFF
	// sample counter wraps before SAMPLES
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(SAMPLES - 1))
		else $error("sample counter past SAMPLES");

	// channel index stays below CHANNELS
	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		chan_q <= CHAN_W'(CHANNELS - 1))
		else $error("channel index past CHANNELS");

	// a finished weight always points back at channel one
	a_wrap_chan: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.weight_valid |-> out.next_channel == '0)
		else $error("weight emitted without channel wrap");

	// intermediate results carry no weight
	a_idle_weight: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.weight_valid |-> out.weight == '0)
		else $error("weight on a non-final beat");

	// input stalls only when every stage is full and the output is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in.ready |-> (&vld_q) && !out.ready)
		else $error("input stalled with room in the pipeline");
`endif

endmodule
